// ===== src/sia_pkg.sv =====
// ----------------------------------------------------------------------------
// sia_pkg
// shared constants and types for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
`default_nettype none

package sia_pkg;

  // magnitude width and conversion step size
  localparam int MAG_W         = 32;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_CYCLES   = MAG_W / BITS_PER_STEP;
  localparam int CONV_CNT_W    = $clog2(CONV_CYCLES);

  // decimal digits needed for a 32-bit magnitude
  localparam int NUM_DIGITS    = 10;
  localparam int DIG_CNT_W     = $clog2(NUM_DIGITS + 1);

  // character codes
  localparam int CHAR_W        = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef logic [3:0] bcd_t;

  // control from the sequencer to every cell of the row
  typedef struct packed {
    logic clr;    // load zero into the digit
    logic conv;   // shift in magnitude bits with add-3 correction
    logic shift;  // take the lower neighbor's digit
  } cell_ctl_t;

endpackage : sia_pkg

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per item
// ----------------------------------------------------------------------------
// Each input item is a signed 32-bit value; the block answers with its decimal
// text, most significant character first: a '-' for negative values, then the
// digits with leading zeros dropped (zero gives a single '0'). out_tlast marks
// the final character. The magnitude is converted by a row of ten bcd digit
// cells (shift-and-add-3), four magnitude bits per cycle. The digits then
// shift up the row one per cycle unless the output register stalls: a leading
// zero is dropped without output, and a character is emitted only when the
// output register is free. One item is worked on at a time, and the next one
// is not accepted until the final character has entered the output register;
// that register holds the final character while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic signed [31:0]  in_tdata,   // [31:0] value
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [5:0] character, [7:6] zero
  output logic                out_tlast   // last character of this number
);
  import sia_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a value
    S_CONV = 4'b0010,  // magnitude bits flowing into the cell row
    S_SIGN = 4'b0100,  // minus sign pending
    S_DIG  = 4'b1000   // digits shifting out of the top cell
  } state_t;

  localparam logic [CONV_CNT_W-1:0] CONV_LAST = CONV_CNT_W'(CONV_CYCLES - 1);
  localparam logic [DIG_CNT_W-1:0]  DIG_FULL  = DIG_CNT_W'(NUM_DIGITS);
  localparam logic [DIG_CNT_W-1:0]  DIG_ONE   = DIG_CNT_W'(1);

  state_t                 state_r, state_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [CONV_CNT_W-1:0]  conv_cnt_r, conv_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;  // digit positions left
  logic                   lead_r, lead_nxt;        // still in leading zeros

  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic [MAG_W-1:0]       in_mag;
  cell_ctl_t              ctl;

  bcd_t                              digit_w [NUM_DIGITS];
  logic [BITS_PER_STEP-1:0]          carry_w [NUM_DIGITS];
  bcd_t                              top_digit;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // two's complement magnitude; the most negative value maps to 2^31
  assign in_mag = in_tdata[31] ? ($unsigned(~in_tdata) + 32'd1) : $unsigned(in_tdata);

  // ---------------------------------------------------------------------------
  // row of digit cells: cell 0 is the units digit, bits climb toward the top
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [BITS_PER_STEP-1:0] bits_in_w;
    bcd_t                     digit_in_w;

    if (i == 0) begin : g_first
      assign bits_in_w  = mag_r[MAG_W-1 -: BITS_PER_STEP];
      assign digit_in_w = '0;
    end else begin : g_rest
      assign bits_in_w  = carry_w[i-1];
      assign digit_in_w = digit_w[i-1];
    end

    sia_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bits_in  (bits_in_w),
      .digit_in (digit_in_w),
      .bits_out (carry_w[i]),
      .digit    (digit_w[i])
    );
  end

  assign top_digit = digit_w[NUM_DIGITS-1];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    conv_cnt_nxt  = conv_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    lead_nxt      = lead_r;
    ctl           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mag_nxt      = in_mag;
          neg_nxt      = in_tdata[31];
          conv_cnt_nxt = '0;
          ctl.clr      = 1'b1;
          state_nxt    = S_CONV;
        end
      end
      S_CONV: begin
        // four magnitude bits enter the row per cycle, msb first
        ctl.conv     = 1'b1;
        mag_nxt      = mag_r << BITS_PER_STEP;
        conv_cnt_nxt = conv_cnt_r + CONV_CNT_W'(1);
        if (conv_cnt_r == CONV_LAST) begin
          dig_cnt_nxt = DIG_FULL;
          lead_nxt    = 1'b1;
          state_nxt   = neg_r ? S_SIGN : S_DIG;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIG;
        end
      end
      S_DIG: begin
        if (lead_r && (top_digit == 4'd0) && (dig_cnt_r != DIG_ONE)) begin
          // drop a leading zero; the units digit is always kept
          ctl.shift   = 1'b1;
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
        end else if (out_free) begin
          ctl.shift     = 1'b1;
          lead_nxt      = 1'b0;
          dig_cnt_nxt   = dig_cnt_r - DIG_CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + CHAR_W'(top_digit);
          out_last_nxt  = (dig_cnt_r == DIG_ONE);
          if (dig_cnt_r == DIG_ONE) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and counters, qualified by the state
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    conv_cnt_r <= conv_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    lead_r     <= lead_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_char_r};
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an accepted value always starts a conversion
  a_acc_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CONV))
    else $error("accepted item did not start conversion");

  // a 32-bit magnitude never overflows the top cell
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> (carry_w[NUM_DIGITS-1] == '0))
    else $error("carry out of the top digit cell");

  // the top cell holds a valid bcd digit while digits are being emitted
  a_top_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG) |-> (top_digit <= 4'd9))
    else $error("top cell digit out of bcd range");

  // the minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == ASCII_MINUS)) |-> !out_last_r)
    else $error("minus sign flagged as last character");

  // a character is a minus sign or a decimal digit
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r == ASCII_MINUS) ||
                     ((out_char_r >= ASCII_ZERO) && (out_char_r <= ASCII_ZERO + 6'd9))))
    else $error("character outside the decimal set");

endmodule : signed_int_to_decimal_ascii

`default_nettype wire

// ===== src/sia_cell.sv =====
// ----------------------------------------------------------------------------
// sia_cell
// one bcd digit cell of the shift-and-add-3 row
// ----------------------------------------------------------------------------
`default_nettype none

module sia_cell (
  input  logic                             clk,
  input  sia_pkg::cell_ctl_t               ctl,
  input  logic [sia_pkg::BITS_PER_STEP-1:0] bits_in,   // msb enters first
  input  sia_pkg::bcd_t                    digit_in,  // lower neighbor's digit
  output logic [sia_pkg::BITS_PER_STEP-1:0] bits_out,  // bits handed upward
  output sia_pkg::bcd_t                    digit
);
  import sia_pkg::*;

  bcd_t digit_r;
  bcd_t digit_nxt;
  bcd_t conv_d;

  // several double-dabble steps on this digit, one per incoming bit
  always_comb begin
    conv_d   = digit_r;
    bits_out = '0;
    for (int k = BITS_PER_STEP - 1; k >= 0; k--) begin
      if (conv_d >= 4'd5) begin
        conv_d = conv_d + 4'd3;
      end
      bits_out[k] = conv_d[3];
      conv_d      = {conv_d[2:0], bits_in[k]};
    end
  end

  always_comb begin
    priority if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.conv) begin
      digit_nxt = conv_d;
    end else if (ctl.shift) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule : sia_cell

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the signed integer to decimal text converter against a predictor
// ----------------------------------------------------------------------------
// A short table of hand-picked values comes first. Rows whose text is obvious
// carry it typed in. The other rows and a few hundred random values go
// through a local predictor. Every character leaving the block is compared
// in order with the oldest expected character, and its last flag is checked
// too. Both sides idle at random, except during one long stretch with no
// idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sia_pkg::*;

  localparam int RANDOM_ITEMS = 260;
  localparam int IDLE_PCT     = 22;
  localparam int MAX_REPORTS  = 10;

  // one expected character of a number's text
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // one directed row: empty text means the predictor supplies it
  typedef struct {
    logic [31:0] value;
    string       text;
  } directed_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic signed [31:0] in_tdata;    // [31:0] value
  logic               out_tvalid;
  logic               out_tready;
  logic [7:0]         out_tdata;   // [5:0] character, [7:6] zero
  logic               out_tlast;

  text_char_t pending_text[$];     // characters still owed by the block
  int         mismatches;
  bit         steady_flow;         // no idling on either side while set

  signed_int_to_decimal_ascii uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decimal text of a signed value, most significant character first
  function automatic void predict_decimal_text(logic [31:0] value);
    logic [31:0] magnitude;
    logic [3:0]  digit_lsf[NUM_DIGITS];
    int          num_digits;
    text_char_t  c;
    magnitude  = value[31] ? (~value + 32'd1) : value;
    num_digits = 0;
    do begin
      digit_lsf[num_digits] = 4'(magnitude % 32'd10);
      magnitude = magnitude / 32'd10;
      num_digits++;
    end while (magnitude != 0 && num_digits < NUM_DIGITS);
    if (value[31]) begin
      c.code = ASCII_MINUS;
      c.last = 1'b0;
      pending_text.push_back(c);
    end
    for (int i = num_digits - 1; i >= 0; i--) begin
      c.code = ASCII_ZERO + CHAR_W'(digit_lsf[i]);
      c.last = (i == 0);
      pending_text.push_back(c);
    end
  endfunction

  // typed-in text, last flag on its final character
  function automatic void expect_typed_text(string text);
    text_char_t c;
    byte        ch;
    for (int i = 0; i < text.len(); i++) begin
      ch     = text[i];
      c.code = ch[CHAR_W-1:0];
      c.last = (i == text.len() - 1);
      pending_text.push_back(c);
    end
  endfunction

  function automatic void report_mismatch(string what, logic [7:0] want_data,
                                          logic want_last);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch (%s): expected data %0d last %0b, got data %0d last %0b",
               $realtime, what, want_data, want_last, out_tdata, out_tlast);
  endfunction

  // random value spread over all text lengths and both signs
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] pow10[10];
    pow10 = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
              32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 20);
      1: v = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 32'd1;
      2: begin
        case ($urandom_range(0, 2))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          default: v = 32'd0;
        endcase
      end
      3: v = $urandom;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1)
      v = -v;
    return v;
  endfunction

  // hand one value to the block, idling first at random; call just after the
  // rising clock edge, returns at the edge that accepted the item
  task automatic send_value(logic [31:0] value, string text);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    if (text.len() != 0)
      expect_typed_text(text);
    else
      predict_decimal_text(value);
  endtask

  // hold off the sender until every owed character has come out
  task automatic drain_text();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_text.size() != 0)
      @(posedge clk);
  endtask

  // receiver: random back-pressure and in-order check of every character
  always @(posedge clk) begin : rx_side
    text_char_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_text.size() == 0) begin
          report_mismatch("nothing expected", 8'd0, 1'b0);
        end else begin
          want = pending_text.pop_front();
          if (out_tdata !== {2'b00, want.code} || out_tlast !== want.last)
            report_mismatch("character", {2'b00, want.code}, want.last);
        end
      end
      out_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // stimulus
  initial begin : stimulus
    directed_row_t directed[] = '{
      '{32'd0,          "0"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h7fff_ffff,  "2147483647"},
      '{32'hffff_ffff,  "-1"},
      '{32'd1,          "1"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{-32'd9,         "-9"},
      '{-32'd10,        "-10"},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'd999999999,  ""},
      '{32'd1000000000, "1000000000"},
      '{-32'd1000000000, "-1000000000"},
      '{32'h5555_5555,  ""},
      '{32'haaaa_aaaa,  ""},
      '{32'd12345,      "12345"},
      '{-32'd987654321, ""},
      '{32'd65536,      ""},
      '{32'd0,          "0"}
    };
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    mismatches  = 0;
    steady_flow = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_value(directed[i].value, directed[i].text);
    drain_text();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // long stretch where neither side idles
      steady_flow = (n >= 100 && n < 160);
      if (n == 200)
        drain_text();
      send_value(pick_value(), "");
    end
    steady_flow = 1'b0;
    in_tvalid <= 1'b0;

    // let the block finish the last text, then a little longer
    while (pending_text.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule : tb

`default_nettype wire

// ===== sim.f =====
src/sia_pkg.sv
src/sia_cell.sv
src/signed_int_to_decimal_ascii.sv
verif/tb.sv
